>>> src/dtps_pkg.sv
// Shared types and constants for the depth tested pixel store.
// Holds the command codes, field widths, controller states and the
// command and status structs between the controller and the datapath.
package dtps_pkg;

    localparam int POS_W      = 12;
    localparam int SPAN_W     = POS_W + 1;
    localparam int FDEPTH_W   = 24;
    localparam int RGBA_W     = 32;
    localparam int SIZE_REG_W = 9;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_RGBA   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_DEPTH  = 2'd3;

    localparam logic [SIZE_REG_W-1:0] FRAME_SIZE_RESET = 9'd256;

    typedef enum logic [CMD_W-1:0] {
        CMD_DRAW  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_INIT_CLR,
        ST_IDLE,
        ST_LOCATE,
        ST_FETCH,
        ST_UPDATE,
        ST_SWEEP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic sweep;
        logic sweep_init;
        logic update;
        logic emit;
    } t_ctrl_cmd;

    typedef struct packed {
        t_cmd op;
        logic sweep_last;
    } t_ctrl_stat;

endpackage

>>> src/dtps_datapath.sv
// Datapath of the depth tested pixel store: color and depth memories,
// position mapping, depth test, clear sweep counter and result registers.
// Depends on dtps_pkg; driven by dtps_ctrl through t_ctrl_cmd.
module dtps_datapath
    import dtps_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int DEPTH_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctrl_cmd             i_cmd,
    output t_ctrl_stat            o_stat,
    input  logic [SIZE_REG_W-1:0] i_frame_width,
    input  logic [SIZE_REG_W-1:0] i_frame_height,
    input  logic [RGBA_W-1:0]     i_clear_rgba,
    input  logic [FDEPTH_W-1:0]   i_clear_depth,
    input  logic [CMD_W-1:0]      i_op,
    input  logic [POS_W-1:0]      i_pos_x,
    input  logic [POS_W-1:0]      i_pos_y,
    input  logic [FDEPTH_W-1:0]   i_frag_depth,
    input  logic [RGBA_W-1:0]     i_frag_rgba,
    input  logic                  i_depth_test_on,
    input  logic                  i_clear_color_sel,
    input  logic                  i_clear_depth_sel,
    output logic [RGBA_W-1:0]     o_pixel_rgba,
    output logic [FDEPTH_W-1:0]   o_pixel_depth,
    output logic                  o_was_written,
    output logic                  o_out_of_frame
);

    localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DW = DEPTH_BITS;

    logic [RGBA_W-1:0] color_mem [STORE_SIZE];
    logic [DW-1:0]     depth_mem [STORE_SIZE];

    t_cmd              r_op;
    logic [POS_W-1:0]  r_pos_x;
    logic [POS_W-1:0]  r_pos_y;
    logic [DW-1:0]     r_depth;
    logic [RGBA_W-1:0] r_rgba;
    logic              r_test;
    logic              r_sel_c;
    logic              r_sel_d;

    logic [AW-1:0]     r_addr;
    logic              r_in_frame;
    logic [RGBA_W-1:0] r_rd_color;
    logic [DW-1:0]     r_rd_depth;
    logic [AW-1:0]     r_sweep_cnt;

    logic [RGBA_W-1:0]   r_res_rgba;
    logic [FDEPTH_W-1:0] r_res_depth;
    logic                r_res_written;
    logic                r_res_oof;

    logic [DW+FDEPTH_W-1:0] frag_ext;
    logic [DW+FDEPTH_W-1:0] clear_ext;
    logic [DW+FDEPTH_W-1:0] rd_ext;
    logic [SPAN_W-1:0]      act_w;
    logic [SPAN_W-1:0]      act_h;
    logic [SPAN_W-1:0]      x_u;
    logic [SPAN_W-1:0]      y_u;
    logic [SPAN_W-1:0]      row_full;
    logic                   n_in_frame;
    logic [AW-1:0]          n_addr;

    logic              pass;
    logic              wr_color_en;
    logic              wr_depth_en;
    logic [AW-1:0]     wr_addr;
    logic [RGBA_W-1:0] wr_color;
    logic [DW-1:0]     wr_depth;

    assign frag_ext  = {{DW{1'b0}}, i_frag_depth};
    assign clear_ext = {{DW{1'b0}}, i_clear_depth};
    assign rd_ext    = {{FDEPTH_W{1'b0}}, r_rd_depth};

    always_comb begin
        act_w = (SPAN_W'(i_frame_width) > SPAN_W'(MAX_WIDTH)) ?
                SPAN_W'(MAX_WIDTH) : SPAN_W'(i_frame_width);
        act_h = (SPAN_W'(i_frame_height) > SPAN_W'(MAX_HEIGHT)) ?
                SPAN_W'(MAX_HEIGHT) : SPAN_W'(i_frame_height);
        x_u = {1'b0, r_pos_x};
        y_u = {1'b0, r_pos_y};
        n_in_frame = !r_pos_x[POS_W-1] && !r_pos_y[POS_W-1] &&
                     (x_u < act_w) && (y_u < act_h);
        // Rows arrive counted from the bottom and are stored top-down.
        row_full = act_h - SPAN_W'(1) - y_u;
        n_addr = AW'(row_full[YW-1:0]) * AW'(MAX_WIDTH) + AW'(x_u[XW-1:0]);
    end

    always_comb begin
        pass = (r_op == CMD_DRAW) && r_in_frame && (!r_test || (r_depth >= r_rd_depth));
        wr_color_en = 1'b0;
        wr_depth_en = 1'b0;
        wr_addr     = r_addr;
        wr_color    = r_rgba;
        wr_depth    = r_depth;
        if (i_cmd.sweep) begin
            wr_addr     = r_sweep_cnt;
            wr_color_en = i_cmd.sweep_init || r_sel_c;
            wr_depth_en = i_cmd.sweep_init || r_sel_d;
            wr_color    = i_cmd.sweep_init ? '0 : i_clear_rgba;
            wr_depth    = i_cmd.sweep_init ? '0 : clear_ext[DW-1:0];
        end else if (i_cmd.update && pass) begin
            wr_color_en = 1'b1;
            wr_depth_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_color_en) begin
            color_mem[wr_addr] <= wr_color;
        end
        r_rd_color <= color_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (wr_depth_en) begin
            depth_mem[wr_addr] <= wr_depth;
        end
        r_rd_depth <= depth_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_cnt <= '0;
        end else if (i_cmd.capture) begin
            r_sweep_cnt <= '0;
        end else if (i_cmd.sweep) begin
            r_sweep_cnt <= r_sweep_cnt + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= t_cmd'(i_op);
            r_pos_x <= i_pos_x;
            r_pos_y <= i_pos_y;
            r_depth <= frag_ext[DW-1:0];
            r_rgba  <= i_frag_rgba;
            r_test  <= i_depth_test_on;
            r_sel_c <= i_clear_color_sel;
            r_sel_d <= i_clear_depth_sel;
        end
        r_addr     <= n_addr;
        r_in_frame <= n_in_frame;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_res_rgba    <= '0;
            r_res_depth   <= '0;
            r_res_written <= 1'b0;
            r_res_oof     <= 1'b0;
        end else if (i_cmd.update) begin
            r_res_rgba    <= (r_op == CMD_READ && r_in_frame) ? r_rd_color : '0;
            r_res_depth   <= (r_op == CMD_READ && r_in_frame) ?
                             rd_ext[FDEPTH_W-1:0] : '0;
            r_res_written <= pass;
            r_res_oof     <= !r_in_frame;
        end
        if (i_cmd.emit) begin
            o_pixel_rgba   <= r_res_rgba;
            o_pixel_depth  <= r_res_depth;
            o_was_written  <= r_res_written;
            o_out_of_frame <= r_res_oof;
        end
    end

    assign o_stat.op         = r_op;
    assign o_stat.sweep_last = (r_sweep_cnt == AW'(STORE_SIZE - 1));

endmodule

>>> src/dtps_ctrl.sv
// Controller state machine of the depth tested pixel store.
// Sequences capture, locate, fetch, update and clear sweeps, and owns
// the stream handshakes. Depends on dtps_pkg.
module dtps_ctrl
    import dtps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_valid,
    output logic       o_s_ready,
    output logic       o_m_valid,
    input  logic       i_m_ready,
    input  t_ctrl_stat i_stat,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_m_valid;
    logic   n_m_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT_CLR;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        n_m_valid = r_m_valid && !i_m_ready;
        case (r_state)
            ST_INIT_CLR: begin
                o_cmd.sweep      = 1'b1;
                o_cmd.sweep_init = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_LOCATE;
                end
            end
            ST_LOCATE: begin
                case (i_stat.op)
                    CMD_DRAW, CMD_READ: n_state = ST_FETCH;
                    CMD_CLEAR:          n_state = ST_SWEEP;
                    default:            n_state = ST_DONE;
                endcase
            end
            ST_FETCH: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = ST_DONE;
            end
            ST_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_m_valid || i_m_ready) begin
                    o_cmd.emit = 1'b1;
                    n_m_valid  = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_m_valid = r_m_valid;

endmodule

>>> src/depth_tested_pixel_store.sv
// Top level of the depth tested pixel store: stream ports, configuration
// registers and the controller and datapath instances.
// Depends on dtps_pkg, dtps_ctrl and dtps_datapath.
//
// Every command gives exactly one result transaction. After reset the block
// clears both stores in a pass over all MAX_WIDTH*MAX_HEIGHT entries and
// accepts no command until it ends; configuration writes are taken
// throughout. A draw or a read runs through locate, fetch, depth test and
// write, and result, the read-modify-write of the color and depth memories,
// before the next command is accepted. A clear sweeps every memory entry,
// one memory entry per cycle. A new command is taken while the previous
// result still waits on the master side.
module depth_tested_pixel_store
    import dtps_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int DEPTH_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // tdata: pos_x, pos_y, frag_depth, frag_rgba, depth_test_on,
    // clear_color_sel, clear_depth_sel, zero fill.
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser: cmd.
    input  logic [CMD_W-1:0]       i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // tdata: pixel_rgba, pixel_depth, was_written, out_of_frame, zero fill.
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    logic [SIZE_REG_W-1:0] r_frame_width;
    logic [SIZE_REG_W-1:0] r_frame_height;
    logic [RGBA_W-1:0]     r_clear_rgba;
    logic [FDEPTH_W-1:0]   r_clear_depth;

    t_ctrl_cmd  cmd;
    t_ctrl_stat stat;

    logic [RGBA_W-1:0]   pixel_rgba;
    logic [FDEPTH_W-1:0] pixel_depth;
    logic                was_written;
    logic                out_of_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_SIZE_RESET;
            r_frame_height <= FRAME_SIZE_RESET;
            r_clear_rgba   <= '0;
            r_clear_depth  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata[SIZE_REG_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata[SIZE_REG_W-1:0];
                CFG_CLEAR_RGBA:   r_clear_rgba   <= i_cfg_wdata[RGBA_W-1:0];
                CFG_CLEAR_DEPTH:  r_clear_depth  <= i_cfg_wdata[FDEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    dtps_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    dtps_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_frame_width     (r_frame_width),
        .i_frame_height    (r_frame_height),
        .i_clear_rgba      (r_clear_rgba),
        .i_clear_depth     (r_clear_depth),
        .i_op              (i_s_axis_tuser),
        .i_pos_x           (i_s_axis_tdata[11:0]),
        .i_pos_y           (i_s_axis_tdata[23:12]),
        .i_frag_depth      (i_s_axis_tdata[47:24]),
        .i_frag_rgba       (i_s_axis_tdata[79:48]),
        .i_depth_test_on   (i_s_axis_tdata[80]),
        .i_clear_color_sel (i_s_axis_tdata[81]),
        .i_clear_depth_sel (i_s_axis_tdata[82]),
        .o_pixel_rgba      (pixel_rgba),
        .o_pixel_depth     (pixel_depth),
        .o_was_written     (was_written),
        .o_out_of_frame    (out_of_frame)
    );

    assign o_m_axis_tdata = {6'd0, out_of_frame, was_written, pixel_depth, pixel_rgba};

endmodule
